FILE: hw/rtl/iths_pkg.sv
`timescale 1ns / 1ps

package iths_pkg;

  // byte counter width
  localparam int unsigned POS_W = 16;

  // queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // ip versions and transport protocols
  localparam logic [3:0] IP_V4     = 4'd4;
  localparam logic [3:0] IP_V6     = 4'd6;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // header geometry
  localparam logic [3:0] IHL_MIN        = 4'd5;
  localparam logic [5:0] IPV6_HDR_LEN   = 6'd40;
  localparam logic [6:0] UDP_HDR_LEN    = 7'd8;
  localparam logic [6:0] TCP_HDR_MIN    = 7'd20;
  localparam logic [6:0] MIN_PACKET_LEN = 7'd20;
  localparam int unsigned V4_PROTO_POS  = 9;
  localparam int unsigned V6_PROTO_POS  = 6;
  localparam int unsigned TCP_OFF_POS   = 12;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_VERSION    = 3'd2,
    ST_IHL        = 3'd3,
    ST_TCP_OFFSET = 3'd4,
    ST_PROTOCOL   = 3'd5
  } status_t;

  // one result word
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
    status_t    status;
  } res_t;

  // write side of the queue
  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  // queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: hw/rtl/iths_front.sv
`timescale 1ns / 1ps

module iths_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                accept,
  output iths_pkg::push_t     push
);

  localparam int unsigned PW = iths_pkg::POS_W;

  logic [PW-1:0]        pos;
  logic [3:0]           ver;
  logic [5:0]           ip_len;
  logic [7:0]           proto;
  logic [6:0]           hdr_total;
  iths_pkg::status_t    drop;

  logic [3:0]           ver_next;
  logic [5:0]           ip_len_next;
  logic [7:0]           proto_next;
  logic [6:0]           hdr_total_next;
  iths_pkg::status_t    drop_next;
  logic [5:0]           tcp_off;
  logic                 payload;
  logic [PW:0]          len;
  iths_pkg::status_t    final_st;

  // header field capture for this byte
  always_comb begin
    ver_next       = ver;
    ip_len_next    = ip_len;
    proto_next     = proto;
    hdr_total_next = hdr_total;
    drop_next      = drop;
    tcp_off        = {in_byte[7:4], 2'b00};
    if (pos == '0) begin
      ver_next = in_byte[7:4];
      if (in_byte[7:4] == iths_pkg::IP_V4) begin
        ip_len_next = {in_byte[3:0], 2'b00};
        if (in_byte[3:0] < iths_pkg::IHL_MIN) drop_next = iths_pkg::ST_IHL;
      end else if (in_byte[7:4] == iths_pkg::IP_V6) begin
        ip_len_next = iths_pkg::IPV6_HDR_LEN;
      end else begin
        drop_next = iths_pkg::ST_VERSION;
      end
    end else if (drop == iths_pkg::ST_OK) begin
      if ((ver == iths_pkg::IP_V4 && pos == PW'(iths_pkg::V4_PROTO_POS)) ||
          (ver == iths_pkg::IP_V6 && pos == PW'(iths_pkg::V6_PROTO_POS))) begin
        proto_next = in_byte;
        if (in_byte == iths_pkg::PROTO_UDP) begin
          hdr_total_next = 7'(ip_len) + iths_pkg::UDP_HDR_LEN;
        end else if (in_byte != iths_pkg::PROTO_TCP) begin
          drop_next = iths_pkg::ST_PROTOCOL;
        end
      end else if (proto == iths_pkg::PROTO_TCP && hdr_total == '0 &&
                   pos == PW'(ip_len) + PW'(iths_pkg::TCP_OFF_POS)) begin
        if (7'(tcp_off) < iths_pkg::TCP_HDR_MIN) begin
          drop_next = iths_pkg::ST_TCP_OFFSET;
        end else begin
          hdr_total_next = 7'(ip_len) + 7'(tcp_off);
        end
      end
    end
  end

  // payload decision and closing status
  always_comb begin
    payload = (drop_next == iths_pkg::ST_OK) && (hdr_total_next != '0) &&
              (pos >= PW'(hdr_total_next));
    len     = {1'b0, pos} + (PW+1)'(1);
    priority if (len < (PW+1)'(iths_pkg::MIN_PACKET_LEN)) begin
      final_st = iths_pkg::ST_SHORT;
    end else if (drop_next == iths_pkg::ST_VERSION || drop_next == iths_pkg::ST_IHL) begin
      final_st = drop_next;
    end else if (len < (PW+1)'(ip_len_next)) begin
      final_st = iths_pkg::ST_SHORT;
    end else if (drop_next == iths_pkg::ST_PROTOCOL) begin
      final_st = iths_pkg::ST_PROTOCOL;
    end else if (proto_next == iths_pkg::PROTO_TCP &&
                 len < (PW+1)'(7'(ip_len_next) + iths_pkg::TCP_HDR_MIN)) begin
      final_st = iths_pkg::ST_SHORT;
    end else if (drop_next == iths_pkg::ST_TCP_OFFSET) begin
      final_st = iths_pkg::ST_TCP_OFFSET;
    end else if (hdr_total_next == '0 || len < (PW+1)'(hdr_total_next)) begin
      final_st = iths_pkg::ST_SHORT;
    end else begin
      final_st = iths_pkg::ST_OK;
    end
  end

  // result word toward the queue
  always_comb begin
    push.valid        = accept && (payload || in_last);
    push.res.data     = payload ? in_byte : 8'd0;
    push.res.has_byte = payload;
    push.res.last     = in_last;
    push.res.status   = (in_last && !payload) ? final_st : iths_pkg::ST_OK;
  end

  // per-packet state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      ver       <= '0;
      ip_len    <= '0;
      proto     <= '0;
      hdr_total <= '0;
      drop      <= iths_pkg::ST_OK;
    end else if (accept) begin
      if (in_last) begin
        pos       <= '0;
        ver       <= '0;
        ip_len    <= '0;
        proto     <= '0;
        hdr_total <= '0;
        drop      <= iths_pkg::ST_OK;
      end else begin
        if (pos != '1) pos <= pos + PW'(1);
        ver       <= ver_next;
        ip_len    <= ip_len_next;
        proto     <= proto_next;
        hdr_total <= hdr_total_next;
        drop      <= drop_next;
      end
    end
  end

endmodule

FILE: hw/rtl/iths_queue.sv
`timescale 1ns / 1ps

module iths_queue (
  input  logic               clk,
  input  logic               rst,
  input  iths_pkg::push_t    push,
  input  logic               pop,
  output iths_pkg::res_t     head,
  output iths_pkg::q_stat_t  stat
);

  localparam int unsigned AW = iths_pkg::QUEUE_AW;

  iths_pkg::res_t mem [iths_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           do_pop;

  assign do_pop     = pop && (count != '0);
  assign head       = mem[rd_ptr];
  assign stat.full  = (count == (AW+1)'(iths_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.res;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + AW'(1);
      if (do_pop) rd_ptr <= rd_ptr + AW'(1);
      if (push.valid && !do_pop) count <= count + (AW+1)'(1);
      else if (!push.valid && do_pop) count <= count - (AW+1)'(1);
    end
  end

endmodule

FILE: hw/rtl/iths_back.sv
`timescale 1ns / 1ps

module iths_back (
  input  logic               clk,
  input  logic               rst,
  input  iths_pkg::res_t     head,
  input  iths_pkg::q_stat_t  stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output iths_pkg::res_t     out_res
);

  // refill the output register when it is free or being taken
  assign pop = !stat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= !stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_res <= head;
  end

endmodule

FILE: hw/rtl/ip_transport_header_stripper.sv
`timescale 1ns / 1ps

// Strips IPv4/IPv6 and TCP/UDP headers from a byte stream, one byte per word,
// and passes on only the payload bytes; the last byte of each packet yields a
// word with tlast set, and when that byte is not itself payload the word carries
// no byte (tuser low) and a status in tdata[10:8]: 0 ok, 1 too short,
// 2 bad version, 3 bad IHL, 4 bad TCP offset, 5 unsupported protocol.
// Header bytes of packets give no output. One byte is accepted every cycle
// while the queue has room; the parser decides each byte in the cycle it
// arrives, and results are written into a 4-word queue and then taken into an
// output register, and s_tready falls only when the queue is full.
// IPv6 extension headers are not parsed and count as unsupported.
module ip_transport_header_stripper (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] out_status, rest zero
  output logic        m_tuser,   // out_has_byte
  output logic        m_tlast
);

  iths_pkg::push_t    push;
  iths_pkg::res_t     head;
  iths_pkg::res_t     out_res;
  iths_pkg::q_stat_t  stat;
  logic               pop;
  logic               accept;

  assign s_tready = !stat.full;
  assign accept   = s_tvalid && s_tready;

  // parser and classifier
  iths_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_byte (s_tdata),
    .in_last (s_tlast),
    .accept  (accept),
    .push    (push)
  );

  // result queue
  iths_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  // output register
  iths_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {5'd0, out_res.status, out_res.data};
  assign m_tuser = out_res.has_byte;
  assign m_tlast = out_res.last;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned POS_MAX     = (1 << iths_pkg::POS_W) - 1;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned RAND_PKTS   = 2;

  // header stripper prediction and the words still owed by the block
  class strip_scoreboard;
    int unsigned        pos;
    logic [3:0]         ver;
    int unsigned        ip_len;
    logic [7:0]         proto;
    int unsigned        hdr_total;
    iths_pkg::status_t  drop;
    iths_pkg::res_t     owed_q[$];
    int unsigned        errors;

    function new();
      clear_packet();
      errors = 0;
    endfunction

    function void clear_packet();
      pos       = 0;
      ver       = '0;
      ip_len    = 0;
      proto     = '0;
      hdr_total = 0;
      drop      = iths_pkg::ST_OK;
    endfunction

    function int unsigned owed();
      return owed_q.size();
    endfunction

    // status of a packet that closes on a header byte
    function iths_pkg::status_t close_status(int unsigned len);
      if (len < 20) return iths_pkg::ST_SHORT;
      if (drop == iths_pkg::ST_VERSION || drop == iths_pkg::ST_IHL) return drop;
      if (len < ip_len) return iths_pkg::ST_SHORT;
      if (drop == iths_pkg::ST_PROTOCOL) return iths_pkg::ST_PROTOCOL;
      if (proto == iths_pkg::PROTO_TCP && len < ip_len + 20) return iths_pkg::ST_SHORT;
      if (drop == iths_pkg::ST_TCP_OFFSET) return iths_pkg::ST_TCP_OFFSET;
      if (hdr_total == 0 || len < hdr_total) return iths_pkg::ST_SHORT;
      return iths_pkg::ST_OK;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int unsigned    p;
      int unsigned    off;
      logic           payload;
      iths_pkg::res_t exp;
      p = pos;
      // header parsing
      if (p == 0) begin
        ver = b[7:4];
        if (ver == iths_pkg::IP_V4) begin
          ip_len = b[3:0] * 4;
          if (b[3:0] < iths_pkg::IHL_MIN) drop = iths_pkg::ST_IHL;
        end else if (ver == iths_pkg::IP_V6) begin
          ip_len = 40;
        end else begin
          drop = iths_pkg::ST_VERSION;
        end
      end else if (drop == iths_pkg::ST_OK) begin
        if ((ver == iths_pkg::IP_V4 && p == iths_pkg::V4_PROTO_POS) ||
            (ver == iths_pkg::IP_V6 && p == iths_pkg::V6_PROTO_POS)) begin
          proto = b;
          if (b == iths_pkg::PROTO_UDP) hdr_total = ip_len + 8;
          else if (b != iths_pkg::PROTO_TCP) drop = iths_pkg::ST_PROTOCOL;
        end else if (proto == iths_pkg::PROTO_TCP && hdr_total == 0 &&
                     p == ip_len + iths_pkg::TCP_OFF_POS) begin
          off = b[7:4] * 4;
          if (off < 20) drop = iths_pkg::ST_TCP_OFFSET;
          else hdr_total = ip_len + off;
        end
      end
      payload = (drop == iths_pkg::ST_OK) && (hdr_total != 0) && (p >= hdr_total);
      // result word, if any
      if (payload) begin
        exp.data     = b;
        exp.has_byte = 1'b1;
        exp.last     = last;
        exp.status   = iths_pkg::ST_OK;
        owed_q.push_back(exp);
      end else if (last) begin
        exp.data     = '0;
        exp.has_byte = 1'b0;
        exp.last     = 1'b1;
        exp.status   = close_status(p + 1);
        owed_q.push_back(exp);
      end
      if (last) clear_packet();
      else if (p < POS_MAX) pos = p + 1;
    endfunction

    function void check_word(logic [15:0] tdata, logic has_byte, logic last);
      iths_pkg::res_t exp;
      if (owed_q.size() == 0) begin
        $error("unexpected result word: tdata %h tuser %b tlast %b", tdata, has_byte, last);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      if (tdata[7:0] !== exp.data) begin
        $error("out_byte: expected %0d, actual %0d", exp.data, tdata[7:0]);
        errors++;
      end
      if (has_byte !== exp.has_byte) begin
        $error("out_has_byte: expected %0d, actual %0d", exp.has_byte, has_byte);
        errors++;
      end
      if (last !== exp.last) begin
        $error("out_last: expected %0d, actual %0d", exp.last, last);
        errors++;
      end
      if (tdata[10:8] !== exp.status) begin
        $error("out_status: expected %0d, actual %0d", exp.status, tdata[10:8]);
        errors++;
      end
      if (tdata[15:11] !== 5'd0) begin
        $error("tdata padding: expected 0, actual %0d", tdata[15:11]);
        errors++;
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  strip_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        burst          = 1'b0;
  int unsigned quiet_cycles   = 0;
  logic [7:0]  pkt_q[$];

  ip_transport_header_stripper uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // receiver backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // accepted input words feed the prediction
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
  end

  // accepted result words are checked
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser, m_tlast);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL ip_transport_header_stripper");
        $finish;
      end
    end
  end

  // build a packet: random bytes with version, protocol and tcp offset placed
  task automatic make_packet(input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [7:0] proto, input logic [3:0] off,
                             input int unsigned len);
    int unsigned ip_len;
    ip_len = (ver == iths_pkg::IP_V6) ? 40 : ihl * 4;
    pkt_q.delete();
    for (int unsigned i = 0; i < len; i++) pkt_q.push_back(8'($urandom));
    if (len > 0) pkt_q[0] = {ver, ihl};
    if (ver == iths_pkg::IP_V4 && len > iths_pkg::V4_PROTO_POS)
      pkt_q[iths_pkg::V4_PROTO_POS] = proto;
    if (ver == iths_pkg::IP_V6 && len > iths_pkg::V6_PROTO_POS)
      pkt_q[iths_pkg::V6_PROTO_POS] = proto;
    if (proto == iths_pkg::PROTO_TCP && ip_len + iths_pkg::TCP_OFF_POS < len)
      pkt_q[ip_len + iths_pkg::TCP_OFF_POS][7:4] = off;
  endtask

  // header length of a well-formed packet
  function automatic int unsigned hdr_len(logic [3:0] ver, logic [3:0] ihl,
                                          logic [7:0] proto, logic [3:0] off);
    int unsigned ip_len;
    ip_len = (ver == iths_pkg::IP_V6) ? 40 : ihl * 4;
    if (proto == iths_pkg::PROTO_UDP) return ip_len + 8;
    if (proto == iths_pkg::PROTO_TCP) return ip_len + off * 4;
    return ip_len;
  endfunction

  // one word on the slave side, with random sender gaps
  task automatic push_byte(input logic [7:0] b, input logic last);
    while (!burst && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_packet();
    burst = ($urandom_range(0, 99) < 20);
    foreach (pkt_q[i]) push_byte(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  task automatic send_built(input logic [3:0] ver, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [3:0] off,
                            input int unsigned len);
    make_packet(ver, ihl, proto, off, len);
    send_packet();
  endtask

  // sender holds off until the block has delivered everything
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
  endtask

  // mostly well-formed packets, the rest broken or truncated
  task automatic rand_packet();
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [3:0]  off;
    int unsigned hdr;
    int unsigned len;
    int unsigned k;
    ver   = $urandom_range(0, 1) ? iths_pkg::IP_V4 : iths_pkg::IP_V6;
    ihl   = 4'($urandom_range(5, 15));
    proto = $urandom_range(0, 1) ? iths_pkg::PROTO_UDP : iths_pkg::PROTO_TCP;
    off   = 4'($urandom_range(5, 15));
    k     = $urandom_range(0, 99);
    if (k >= 80 && k < 85) begin
      do ver = 4'($urandom); while (ver == iths_pkg::IP_V4 || ver == iths_pkg::IP_V6);
    end else if (k >= 85 && k < 89) begin
      ver = iths_pkg::IP_V4;
      ihl = 4'($urandom_range(0, 4));
    end else if (k >= 89 && k < 94) begin
      do proto = 8'($urandom);
      while (proto == iths_pkg::PROTO_UDP || proto == iths_pkg::PROTO_TCP);
    end else if (k >= 94 && k < 97) begin
      proto = iths_pkg::PROTO_TCP;
      off   = 4'($urandom_range(0, 4));
    end else if (k >= 97) begin
      ver   = 4'($urandom);
      ihl   = 4'($urandom);
      proto = 8'($urandom);
      off   = 4'($urandom);
    end
    hdr = hdr_len(ver, ihl, proto, off);
    if (k >= 70 && k < 80) len = $urandom_range(1, hdr);
    else if (k >= 80) len = $urandom_range(1, 70);
    else len = hdr + $urandom_range(0, 12);
    send_built(ver, ihl, proto, off, len);
  endtask

  task automatic rand_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (RAND_PKTS) rand_packet();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed packets
    send_built(iths_pkg::IP_V4, 4'd5, iths_pkg::PROTO_UDP, 4'd0, 28 + 4);
    send_built(iths_pkg::IP_V4, 4'd5, iths_pkg::PROTO_TCP, 4'd5, 40 + 3);
    send_built(4'd0, 4'd5, iths_pkg::PROTO_UDP, 4'd0, 5);    // short beats bad version
    send_built(iths_pkg::IP_V4, 4'd0, iths_pkg::PROTO_TCP, 4'd5, 20);
    send_built(iths_pkg::IP_V4, 4'd5, 8'd255, 4'd0, 20);
    send_built(iths_pkg::IP_V6, 4'd0, 8'd0, 4'd0, 41);       // extension header
    send_built(iths_pkg::IP_V4, 4'd5, iths_pkg::PROTO_TCP, 4'd4, 40);
    send_built(iths_pkg::IP_V4, 4'd5, iths_pkg::PROTO_UDP, 4'd0, 1);
    send_built(iths_pkg::IP_V4, 4'd5, iths_pkg::PROTO_UDP, 4'd0, 19);
    send_built(iths_pkg::IP_V4, 4'd10, iths_pkg::PROTO_UDP, 4'd0, 30); // ends inside ip header
    send_built(iths_pkg::IP_V4, 4'd5, iths_pkg::PROTO_TCP, 4'd5, 35);  // ends inside tcp minimum
    send_built(iths_pkg::IP_V4, 4'd5, iths_pkg::PROTO_UDP, 4'd0, 28);  // empty payload

    // random phases with different idling
    rand_phase(0, 0);
    drain();
    rand_phase(72, 0);
    drain();
    rand_phase(0, 72);
    drain();
    rand_phase(25, 25);

    s_tvalid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS ip_transport_header_stripper");
    end else begin
      $display("FAIL ip_transport_header_stripper");
    end
    $finish;
  end

endmodule
